>>> rtl/core/cyclic_position_setpoint_generator_top_macros.svh
// Assertion macros for the cyclic position setpoint generator.
`ifndef CYCLIC_POSITION_SETPOINT_GENERATOR_TOP_MACROS_SVH
`define CYCLIC_POSITION_SETPOINT_GENERATOR_TOP_MACROS_SVH
`ifndef SYNTHESIS
// Condition that must hold in the same cycle as its trigger.
`define CPSG_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);
// Condition that must hold in the cycle after its trigger.
`define CPSG_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);
`else
`define CPSG_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg)
`define CPSG_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

>>> rtl/core/cpsg_pkg.sv
// Shared constants, types and decode function for the setpoint generator.
`default_nettype none
package cpsg_pkg;

  localparam int FRAC_BITS_DEFAULT = 16;
  localparam int POS_W  = 32;
  localparam int STEP_W = 48;
  localparam int CFG_W  = 48;
  localparam int IDX_W  = 3;
  localparam int OPT_W  = 7;
  localparam int ST_W   = 4;

  // Input item kinds
  localparam logic [1:0] KIND_FEEDBACK = 2'd0;
  localparam logic [1:0] KIND_TARGET   = 2'd1;
  localparam logic [1:0] KIND_TICK     = 2'd2;

  // Register indexes
  localparam logic [IDX_W-1:0] CFG_RUN_MODE  = 3'd0;
  localparam logic [IDX_W-1:0] CFG_OPTIONS   = 3'd1;
  localparam logic [IDX_W-1:0] CFG_FIXED_TGT = 3'd2;
  localparam logic [IDX_W-1:0] CFG_START_POS = 3'd3;
  localparam logic [IDX_W-1:0] CFG_STEP      = 3'd4;
  localparam logic [IDX_W-1:0] CFG_SPEED     = 3'd5;

  // Option flag bit positions
  localparam int OPT_TARGET   = 0;
  localparam int OPT_START    = 1;
  localparam int OPT_STEP     = 2;
  localparam int OPT_SPEED    = 3;
  localparam int OPT_REQ_EN   = 4;
  localparam int OPT_REQ_MODE = 5;
  localparam int OPT_AUTO_EN  = 6;

  // Operating mode codes
  localparam logic signed [7:0] OP_MODE_CSP = 8'sd8;
  localparam logic signed [7:0] OP_MODE_CSV = 8'sd9;

  // CiA402 drive states
  localparam logic [ST_W-1:0] ST_NOT_READY     = 4'd0;
  localparam logic [ST_W-1:0] ST_SWITCH_ON_DIS = 4'd1;
  localparam logic [ST_W-1:0] ST_READY         = 4'd2;
  localparam logic [ST_W-1:0] ST_SWITCHED_ON   = 4'd3;
  localparam logic [ST_W-1:0] ST_ENABLED       = 4'd4;
  localparam logic [ST_W-1:0] ST_QUICK_STOP    = 4'd5;
  localparam logic [ST_W-1:0] ST_FAULT_REACT   = 4'd6;
  localparam logic [ST_W-1:0] ST_FAULT         = 4'd7;
  localparam logic [ST_W-1:0] ST_UNKNOWN       = 4'd8;
  localparam logic [ST_W-1:0] ST_NONE          = 4'd9;

  // Status word masks and patterns
  localparam logic [15:0] SW_MASK_A      = 16'h006F;
  localparam logic [15:0] SW_MASK_B      = 16'h004F;
  localparam logic [15:0] SW_NOT_READY   = 16'h0000;
  localparam logic [15:0] SW_SW_ON_DIS   = 16'h0040;
  localparam logic [15:0] SW_READY       = 16'h0021;
  localparam logic [15:0] SW_SWITCHED_ON = 16'h0023;
  localparam logic [15:0] SW_ENABLED     = 16'h0027;
  localparam logic [15:0] SW_QUICK_STOP  = 16'h0007;
  localparam logic [15:0] SW_FAULT_REACT = 16'h000F;
  localparam logic [15:0] SW_FAULT       = 16'h0008;

  // Control inputs of the position unit
  typedef struct packed {
    logic opt_start;
    logic opt_step;
    logic opt_speed;
    logic has_target;
    logic acc_valid;
    logic pos_valid;
  } pos_ctrl_t;

  function automatic logic [ST_W-1:0] decode_state(input logic [15:0] sw);
    logic [15:0] a;
    logic [15:0] b;
    a = sw & SW_MASK_A;
    b = sw & SW_MASK_B;
    if (b == SW_NOT_READY) return ST_NOT_READY;
    else if (b == SW_SW_ON_DIS) return ST_SWITCH_ON_DIS;
    else if (a == SW_READY) return ST_READY;
    else if (a == SW_SWITCHED_ON) return ST_SWITCHED_ON;
    else if (a == SW_ENABLED) return ST_ENABLED;
    else if (a == SW_QUICK_STOP) return ST_QUICK_STOP;
    else if (b == SW_FAULT_REACT) return ST_FAULT_REACT;
    else if (b == SW_FAULT) return ST_FAULT;
    else return ST_UNKNOWN;
  endfunction

endpackage
`default_nettype wire

>>> rtl/core/cpsg_pos_unit.sv
// Position setpoint update: seed, slew/step, clamp, round and saturate.
`default_nettype none
module cpsg_pos_unit import cpsg_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEFAULT
) (
  input  pos_ctrl_t                          ctrl_i,
  input  logic signed [POS_W+FRAC_BITS-1:0]  acc_i,
  input  logic signed [POS_W-1:0]            start_i,
  input  logic signed [POS_W-1:0]            last_pos_i,
  input  logic signed [POS_W-1:0]            target_i,
  input  logic signed [STEP_W-1:0]           step_i,
  input  logic signed [STEP_W-1:0]           speed_i,
  output logic signed [POS_W+FRAC_BITS-1:0]  acc_o,
  output logic signed [POS_W-1:0]            cmd_o
);

  localparam int ACC_W = POS_W + FRAC_BITS;
  localparam int SUM_W = ((ACC_W > STEP_W) ? ACC_W : STEP_W) + 2;
  localparam logic signed [SUM_W-1:0] ACC_HI =
    $signed((SUM_W'(1) << (ACC_W - 1)) - SUM_W'(1));
  localparam logic signed [SUM_W-1:0] ACC_LO = ~ACC_HI;
  localparam logic [ACC_W:0] HALF = ((ACC_W+1)'(1) << FRAC_BITS) >> 1;
  localparam logic [POS_W:0] Q_MIN_MAG = (POS_W+1)'(1) << (POS_W - 1);
  localparam logic signed [POS_W-1:0] CMD_MAX = {1'b0, {(POS_W-1){1'b1}}};
  localparam logic signed [POS_W-1:0] CMD_MIN = {1'b1, {(POS_W-1){1'b0}}};

  logic signed [POS_W-1:0] seed;
  logic signed [SUM_W-1:0] seed_w, base_w, tgt_w, step_w, speed_w, lim_w;
  logic signed [SUM_W-1:0] diff_w, nxt_w, acc_c, neg_c;
  logic                    acc_neg;
  logic [ACC_W:0]          mag, rnd, quo;
  logic [POS_W:0]          q, neg_q;

  assign seed   = ctrl_i.opt_start ? start_i : (ctrl_i.pos_valid ? last_pos_i : '0);
  assign seed_w = $signed({{(SUM_W-POS_W){seed[POS_W-1]}}, seed}) <<< FRAC_BITS;
  assign base_w = ctrl_i.acc_valid ? $signed({{(SUM_W-ACC_W){acc_i[ACC_W-1]}}, acc_i})
                                   : seed_w;
  assign tgt_w  = $signed({{(SUM_W-POS_W){target_i[POS_W-1]}}, target_i}) <<< FRAC_BITS;
  assign step_w  = $signed({{(SUM_W-STEP_W){step_i[STEP_W-1]}}, step_i});
  assign speed_w = $signed({{(SUM_W-STEP_W){speed_i[STEP_W-1]}}, speed_i});
  assign lim_w   = speed_w[SUM_W-1] ? -speed_w : speed_w;
  assign diff_w  = tgt_w - base_w;

  always_comb begin
    nxt_w = base_w;
    if (ctrl_i.has_target && ctrl_i.opt_speed) begin
      if (diff_w > lim_w) begin
        nxt_w = base_w + lim_w;
      end else if (diff_w < -lim_w) begin
        nxt_w = base_w - lim_w;
      end else begin
        nxt_w = tgt_w;
      end
    end else if (ctrl_i.opt_step) begin
      nxt_w = base_w + step_w;
    end else if (ctrl_i.opt_speed) begin
      nxt_w = base_w + speed_w;
    end else if (ctrl_i.has_target) begin
      nxt_w = tgt_w;
    end
  end

  // Saturate to the accumulator range
  always_comb begin
    if (nxt_w > ACC_HI) begin
      acc_c = ACC_HI;
    end else if (nxt_w < ACC_LO) begin
      acc_c = ACC_LO;
    end else begin
      acc_c = nxt_w;
    end
  end

  assign acc_o = acc_c[ACC_W-1:0];

  // Round half away from zero on the magnitude, then saturate to 32 bits
  assign acc_neg = acc_c[SUM_W-1];
  assign neg_c   = -acc_c;
  assign mag     = acc_neg ? neg_c[ACC_W:0] : acc_c[ACC_W:0];
  assign rnd     = mag + HALF;
  assign quo     = rnd >> FRAC_BITS;
  assign q       = quo[POS_W:0];
  assign neg_q   = -q;

  always_comb begin
    if (acc_neg) begin
      cmd_o = (q > Q_MIN_MAG) ? CMD_MIN : $signed(neg_q[POS_W-1:0]);
    end else begin
      cmd_o = (q[POS_W:POS_W-1] != 2'b00) ? CMD_MAX : $signed(q[POS_W-1:0]);
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/cyclic_position_setpoint_generator_top.sv
// Top level of the CiA402 cyclic position / velocity setpoint generator.
//
// Usage:
//  - s_axis carries input items. tuser holds the kind (feedback, dynamic
//    target, cycle tick); tdata holds status word, operating mode display,
//    actual position and new target. Feedback and target transfers only
//    update held state; each tick transfer yields exactly one result.
//  - m_axis carries results: tuser holds the issued flag, tdata holds the
//    command, the decoded drive state and the enable request.
//  - cfg_we_i / cfg_idx_i / cfg_wdata_i write one of the six configuration
//    registers per cycle; write them only while the block is idle.
// Timing:
//  - An accepted item lands in the input register, is processed by one pass
//    of combinational logic and, for a tick, lands in the output register
//    once that register has room, which raises m_axis_tvalid.
//  - Throughput is one item per cycle while no tick waits on a stalled m_axis.
//    The setpoint accumulator loop closes through acc_q alone, so ticks may follow back to back.
//  - When m_axis stalls, the output register holds its result; feedback and
//    target items pass until a tick waits in the input register, then s_axis stalls.
// Reset clears all valid bits, the accumulator and the configuration.
`default_nettype none
`include "cyclic_position_setpoint_generator_top_macros.svh"
module cyclic_position_setpoint_generator_top import cpsg_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEFAULT
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // Input stream
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  // [15:0] drive status, [23:16] mode display, [55:24] measured position,
  // [87:56] new_target
  input  logic [87:0]       s_axis_tdata,
  // [1:0] kind
  input  logic [1:0]        s_axis_tuser,
  // Result stream
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  // [31:0] command_value, [35:32] drive_state, [36] enable_request,
  // [39:37] zero
  output logic [39:0]       m_axis_tdata,
  // [0] issued
  output logic [0:0]        m_axis_tuser,
  // Configuration write port
  input  logic              cfg_we_i,
  input  logic [IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_W-1:0]  cfg_wdata_i
);

  localparam int ACC_W = POS_W + FRAC_BITS;

  // Configuration registers
  logic                     run_mode_q;
  logic [OPT_W-1:0]         opt_q;
  logic signed [POS_W-1:0]  fixed_tgt_q;
  logic signed [POS_W-1:0]  start_pos_q;
  logic signed [STEP_W-1:0] step_q;
  logic signed [STEP_W-1:0] speed_q;

  // Held state
  logic signed [ACC_W-1:0]  acc_q, acc_d;
  logic                     acc_vld_q, acc_vld_d;
  logic [15:0]              stat_q;
  logic                     stat_vld_q;
  logic signed [7:0]        opm_q;
  logic                     opm_vld_q;
  logic signed [POS_W-1:0]  lpos_q;
  logic                     lpos_vld_q;
  logic signed [POS_W-1:0]  dtgt_q;
  logic                     dtgt_vld_q;

  // Input register
  logic                     in_vld_q, in_vld_d;
  logic [1:0]               in_kind_q;
  logic [15:0]              in_stat_q;
  logic signed [7:0]        in_opm_q;
  logic signed [POS_W-1:0]  in_pos_q;
  logic signed [POS_W-1:0]  in_tgt_q;

  // Output register
  logic                     out_vld_q, out_vld_d;
  logic                     out_issued_q;
  logic signed [POS_W-1:0]  out_cmd_q;
  logic [ST_W-1:0]          out_state_q;
  logic                     out_enreq_q;

  logic                     in_take;
  logic                     is_tick;
  logic                     stage_go;
  logic                     tick_go;
  logic [ST_W-1:0]          drv_state;
  logic                     held;
  logic                     enreq;
  logic signed [7:0]        want_mode;
  logic signed [POS_W-1:0]  eff_tgt;
  logic signed [POS_W-1:0]  cmd;
  pos_ctrl_t                pos_ctrl;
  logic signed [ACC_W-1:0]  acc_nxt;
  logic signed [POS_W-1:0]  pos_cmd;

  // Handshake: a tick needs room in the output register, other kinds do not
  assign is_tick       = (in_kind_q == KIND_TICK);
  assign stage_go      = in_vld_q && (!is_tick || !out_vld_q || m_axis_tready);
  assign tick_go       = stage_go && is_tick;
  assign s_axis_tready = !in_vld_q || stage_go;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  assign in_vld_d  = in_take ? 1'b1 : (stage_go ? 1'b0 : in_vld_q);
  assign out_vld_d = tick_go ? 1'b1 : (m_axis_tready ? 1'b0 : out_vld_q);

  // Decode the drive state and apply gating
  assign drv_state = stat_vld_q ? decode_state(stat_q) : ST_NONE;
  assign want_mode = run_mode_q ? OP_MODE_CSV : OP_MODE_CSP;
  assign held = (opt_q[OPT_REQ_EN] && (drv_state != ST_ENABLED)) ||
                (opt_q[OPT_REQ_MODE] && (!opm_vld_q || (opm_q != want_mode)));
  assign enreq = opt_q[OPT_AUTO_EN] && (drv_state == ST_SWITCHED_ON);

  // Dynamic target wins over the fixed one
  assign eff_tgt = dtgt_vld_q ? dtgt_q : fixed_tgt_q;

  assign pos_ctrl = '{
    opt_start:  opt_q[OPT_START],
    opt_step:   opt_q[OPT_STEP],
    opt_speed:  opt_q[OPT_SPEED],
    has_target: dtgt_vld_q || opt_q[OPT_TARGET],
    acc_valid:  acc_vld_q,
    pos_valid:  lpos_vld_q
  };

  cpsg_pos_unit #(
    .FRAC_BITS (FRAC_BITS)
  ) u_pos (
    .ctrl_i     (pos_ctrl),
    .acc_i      (acc_q),
    .start_i    (start_pos_q),
    .last_pos_i (lpos_q),
    .target_i   (eff_tgt),
    .step_i     (step_q),
    .speed_i    (speed_q),
    .acc_o      (acc_nxt),
    .cmd_o      (pos_cmd)
  );

  always_comb begin
    if (held) begin
      cmd = '0;
    end else if (!run_mode_q) begin
      cmd = pos_cmd;
    end else begin
      cmd = opt_q[OPT_TARGET] ? fixed_tgt_q : '0;
    end
  end

  // Advance the accumulator only on an issued position tick
  assign acc_d     = (tick_go && !held && !run_mode_q) ? acc_nxt : acc_q;
  assign acc_vld_d = (tick_go && !held && !run_mode_q) ? 1'b1 : acc_vld_q;

  // Control and held state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_mode_q  <= 1'b0;
      opt_q       <= '0;
      fixed_tgt_q <= '0;
      start_pos_q <= '0;
      step_q      <= '0;
      speed_q     <= '0;
      acc_q       <= '0;
      acc_vld_q   <= 1'b0;
      stat_q      <= '0;
      stat_vld_q  <= 1'b0;
      opm_q       <= '0;
      opm_vld_q   <= 1'b0;
      lpos_q      <= '0;
      lpos_vld_q  <= 1'b0;
      dtgt_q      <= '0;
      dtgt_vld_q  <= 1'b0;
      in_vld_q    <= 1'b0;
      out_vld_q   <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
      acc_q     <= acc_d;
      acc_vld_q <= acc_vld_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_RUN_MODE:  run_mode_q  <= cfg_wdata_i[0];
          CFG_OPTIONS:   opt_q       <= cfg_wdata_i[OPT_W-1:0];
          CFG_FIXED_TGT: fixed_tgt_q <= $signed(cfg_wdata_i[POS_W-1:0]);
          CFG_START_POS: start_pos_q <= $signed(cfg_wdata_i[POS_W-1:0]);
          CFG_STEP:      step_q      <= $signed(cfg_wdata_i[STEP_W-1:0]);
          CFG_SPEED:     speed_q     <= $signed(cfg_wdata_i[STEP_W-1:0]);
          default: ;
        endcase
      end
      if (stage_go && (in_kind_q == KIND_FEEDBACK)) begin
        stat_q     <= in_stat_q;
        stat_vld_q <= 1'b1;
        opm_q      <= in_opm_q;
        opm_vld_q  <= 1'b1;
        lpos_q     <= in_pos_q;
        lpos_vld_q <= 1'b1;
      end
      if (stage_go && (in_kind_q == KIND_TARGET)) begin
        dtgt_q     <= in_tgt_q;
        dtgt_vld_q <= 1'b1;
      end
    end
  end

  // Payload registers: hold the input item and the result
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_kind_q <= s_axis_tuser;
      in_stat_q <= s_axis_tdata[15:0];
      in_opm_q  <= $signed(s_axis_tdata[23:16]);
      in_pos_q  <= $signed(s_axis_tdata[55:24]);
      in_tgt_q  <= $signed(s_axis_tdata[87:56]);
    end
    if (tick_go) begin
      out_issued_q <= !held;
      out_cmd_q    <= cmd;
      out_state_q  <= drv_state;
      out_enreq_q  <= enreq;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tuser  = out_issued_q;
  assign m_axis_tdata  = {3'b000, out_enreq_q, out_state_q, out_cmd_q};

  // Checks
  `CPSG_ASSERT_SAME(a_held_zero, clk_i, rst_ni, m_axis_tvalid && !out_issued_q, out_cmd_q == '0, "held result carries a nonzero command")
  `CPSG_ASSERT_SAME(a_enreq_state, clk_i, rst_ni, m_axis_tvalid && out_enreq_q, out_state_q == ST_SWITCHED_ON, "enable request outside switched on state")
  `CPSG_ASSERT_NEXT(a_acc_seeded, clk_i, rst_ni, tick_go && !held && !run_mode_q, acc_vld_q, "issued position tick left accumulator unseeded")
  `CPSG_ASSERT_NEXT(a_in_hold, clk_i, rst_ni, in_vld_q && !stage_go, in_vld_q && $stable(in_kind_q), "pending input item lost or overwritten")

endmodule
`default_nettype wire
